@@ hdl/imgconv_pkg.sv @@
package imgconv_pkg;

	localparam int DIM_W            = 12;
	localparam int KSIZE_W          = 5;
	localparam int COEF_IDX_W       = 5;
	localparam int WEIGHT_W         = 16;
	localparam int WEIGHT_FRAC_BITS = 16;
	localparam int CHAN_W           = 8;
	localparam int COORD_W          = 11;
	localparam int CFG_IDX_W        = 2;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_PIXEL = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 2'd2;

	typedef struct packed {
		logic [1:0]            op;
		logic [COEF_IDX_W-1:0] coef_row;
		logic [COEF_IDX_W-1:0] coef_col;
		logic [WEIGHT_W-1:0]   coef_weight;
		logic [CHAN_W-1:0]     pixel_red;
		logic [CHAN_W-1:0]     pixel_green;
		logic [CHAN_W-1:0]     pixel_blue;
		logic [CHAN_W-1:0]     pixel_alpha;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  out_red;
		logic [CHAN_W-1:0]  out_green;
		logic [CHAN_W-1:0]  out_blue;
		logic [CHAN_W-1:0]  out_alpha;
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic               last_of_frame;
	} out_item_t;

endpackage

@@ hdl/image_convolution_2d.sv @@
// Zero-padded 2-D convolution of a raster-order RGBA8 stream with a loaded square kernel
// (Q0.16 weights, results truncated and saturated at 255, emitted in raster order with
// their coordinates). Weight loads and unused op codes return straight to idle; pixel and
// flush items pass through a readiness check, and an item that releases a result then visits
// all K*K taps of a K by K kernel and waits for the output register: one four-lane
// multiply-accumulate unit visits one kernel tap per cycle, fed by a single read port of
// the line memory. There is no clearing pass; the line and weight memories come out of
// reset unwritten. A write to any of the three registers restarts the frame.
module image_convolution_2d #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int MAX_KERNEL = 19
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 src_valid,
	output logic                                 src_stall,
	input  imgconv_pkg::in_item_t                src_data,
	output logic                                 dst_valid,
	input  logic                                 dst_stall,
	output imgconv_pkg::out_item_t               dst_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [imgconv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [imgconv_pkg::DIM_W-1:0]        cfg_data
);
	import imgconv_pkg::*;

	localparam int CW        = $clog2(MAX_WIDTH + 1);
	localparam int RW        = $clog2(MAX_HEIGHT + 1);
	localparam int XW        = $clog2(MAX_WIDTH);
	localparam int KW        = $clog2(MAX_KERNEL + 1);
	localparam int KIW       = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int ROW_SLOTS = MAX_KERNEL + 1;
	localparam int RSW       = $clog2(ROW_SLOTS);
	localparam int LW        = RSW + XW;
	localparam int SXW       = CW + 2;
	localparam int SYW       = RW + 2;
	localparam int AW        = CHAN_W + WEIGHT_W + $clog2(MAX_KERNEL * MAX_KERNEL + 1);
	localparam int PW        = 4 * CHAN_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]         state_q;
	logic [DIM_W-1:0]   width_q, height_q;
	logic [KSIZE_W-1:0] ksize_q;
	logic [CW-1:0]      in_col_q, ox_q;
	logic [RW-1:0]      in_row_q, oy_q;
	logic [RSW-1:0]     in_slot_q, out_slot_q, rs_q;
	logic [KW-1:0]      i_q, j_q;
	logic [SXW-1:0]     xs_q;
	logic [SYW-1:0]     ys_q;
	logic               tap_s1;
	logic [PW-1:0]      px_s1;
	logic [WEIGHT_W-1:0] wt_s1;
	logic [AW-1:0]      acc_q [4];
	logic               dst_valid_q;
	out_item_t          dst_q;

	logic [PW-1:0]       line_mem [ROW_SLOTS << XW];
	logic [WEIGHT_W-1:0] weight_mem [MAX_KERNEL][MAX_KERNEL];

	logic [CW-1:0]  w_eff, wm1, nx;
	logic [RW-1:0]  h_eff, hm1, ny;
	logic [KW-1:0]  ks, half, hp;
	logic [CW:0]    sum_x;
	logic [RW:0]    sum_y;
	logic           ready_c, tap_v, accept, frame_full, weight_we, line_we;
	logic [RSW+1:0] start_slot;
	logic           last_c, emit_go;

	function automatic logic [CHAN_W-1:0] sat_chan(input logic [AW-1:0] a);
		logic [AW-1:0] v;
		v = a >> WEIGHT_FRAC_BITS;
		return (v > AW'(255)) ? CHAN_W'(255) : v[CHAN_W-1:0];
	endfunction

	// Effective sizes: zero widths and heights become one, and oversized values are clamped.
	always_comb begin
		if (width_q == '0) w_eff = CW'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
		else w_eff = CW'(width_q);
		if (height_q == '0) h_eff = RW'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
		else h_eff = RW'(height_q);
		if (32'(ksize_q) > MAX_KERNEL) ks = KW'(MAX_KERNEL);
		else ks = KW'(ksize_q);
		half = ks >> 1;
		hp   = (ks == '0) ? '0 : ks - KW'(1) - half;
		wm1  = w_eff - CW'(1);
		hm1  = h_eff - RW'(1);
		sum_x = (CW+1)'(ox_q) + (CW+1)'(hp);
		sum_y = (RW+1)'(oy_q) + (RW+1)'(hp);
		nx = (sum_x > (CW+1)'(wm1)) ? wm1 : sum_x[CW-1:0];
		ny = (sum_y > (RW+1)'(hm1)) ? hm1 : sum_y[RW-1:0];
		// The bottom-right pixel the window needs has arrived.
		ready_c = (ny < in_row_q) || ((ny == in_row_q) && (nx < in_col_q));
		start_slot = (RSW+2)'(out_slot_q) + (RSW+2)'(ROW_SLOTS) - (RSW+2)'(half);
		if (start_slot >= (RSW+2)'(ROW_SLOTS)) start_slot = start_slot - (RSW+2)'(ROW_SLOTS);
		tap_v = !ys_q[SYW-1] && (ys_q < SYW'(h_eff)) && !xs_q[SXW-1] && (xs_q < SXW'(w_eff));
		frame_full = !(in_row_q < h_eff);
		last_c = (ox_q == wm1) && (oy_q == hm1);
		emit_go = (state_q == ST_EMIT) && (!dst_valid_q || !dst_stall);
	end

	assign src_stall = (state_q != ST_IDLE);
	assign accept    = src_valid && !src_stall;
	assign cfg_ready = 1'b1;
	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_q;
	assign weight_we = accept && (src_data.op == OP_LOAD) &&
		(32'(src_data.coef_row) < MAX_KERNEL) && (32'(src_data.coef_col) < MAX_KERNEL);
	assign line_we   = accept && (src_data.op == OP_PIXEL) && !frame_full;

	always_ff @(posedge clk) begin
		if (weight_we)
			weight_mem[src_data.coef_row[KIW-1:0]][src_data.coef_col[KIW-1:0]] <=
				src_data.coef_weight;
		if (line_we)
			line_mem[LW'({in_slot_q, in_col_q[XW-1:0]})] <= {src_data.pixel_alpha,
				src_data.pixel_blue, src_data.pixel_green, src_data.pixel_red};
		px_s1 <= line_mem[LW'({rs_q, xs_q[XW-1:0]})];
		wt_s1 <= weight_mem[i_q[KIW-1:0]][j_q[KIW-1:0]];
		if (state_q == ST_CHECK) begin
			for (int c = 0; c < 4; c++) acc_q[c] <= '0;
		end else if (tap_s1) begin
			for (int c = 0; c < 4; c++)
				acc_q[c] <= acc_q[c] + AW'(px_s1[CHAN_W*c +: CHAN_W]) * AW'(wt_s1);
		end
		if (emit_go) begin
			dst_q.out_red       <= sat_chan(acc_q[0]);
			dst_q.out_green     <= sat_chan(acc_q[1]);
			dst_q.out_blue      <= sat_chan(acc_q[2]);
			dst_q.out_alpha     <= sat_chan(acc_q[3]);
			dst_q.out_x         <= COORD_W'(ox_q);
			dst_q.out_y         <= COORD_W'(oy_q);
			dst_q.last_of_frame <= last_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= DIM_W'(1920);
			height_q    <= DIM_W'(1080);
			ksize_q     <= KSIZE_W'(19);
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			out_slot_q  <= '0;
			rs_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			xs_q        <= '0;
			ys_q        <= '0;
			tap_s1      <= 1'b0;
			dst_valid_q <= 1'b0;
		end else begin
			tap_s1 <= (state_q == ST_RUN) && tap_v;
			if (emit_go) dst_valid_q <= 1'b1;
			else if (!dst_stall) dst_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (src_data.op)
							OP_PIXEL: begin
								if (!frame_full) begin
									if (in_col_q == wm1) begin
										in_col_q  <= '0;
										in_row_q  <= in_row_q + RW'(1);
										in_slot_q <= (in_slot_q == RSW'(ROW_SLOTS - 1)) ?
											'0 : in_slot_q + RSW'(1);
									end else begin
										in_col_q <= in_col_q + CW'(1);
									end
								end
								state_q <= ST_CHECK;
							end
							OP_FLUSH: state_q <= ST_CHECK;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CHECK: begin
					i_q  <= '0;
					j_q  <= '0;
					ys_q <= SYW'(oy_q) - SYW'(half);
					xs_q <= SXW'(ox_q) - SXW'(half);
					rs_q <= start_slot[RSW-1:0];
					if (!ready_c) state_q <= ST_IDLE;
					else if (ks == '0) state_q <= ST_DRAIN;
					else state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (j_q == ks - KW'(1)) begin
						j_q <= '0;
						if (i_q == ks - KW'(1)) begin
							state_q <= ST_DRAIN;
						end else begin
							i_q  <= i_q + KW'(1);
							ys_q <= ys_q + SYW'(1);
							xs_q <= SXW'(ox_q) - SXW'(half);
							rs_q <= (rs_q == RSW'(ROW_SLOTS - 1)) ? '0 : rs_q + RSW'(1);
						end
					end else begin
						j_q  <= j_q + KW'(1);
						xs_q <= xs_q + SXW'(1);
					end
				end
				ST_DRAIN: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
						if (last_c) begin
							// Frame complete: both positions return to the start.
							ox_q       <= '0;
							oy_q       <= '0;
							out_slot_q <= '0;
							in_col_q   <= '0;
							in_row_q   <= '0;
							in_slot_q  <= '0;
						end else if (ox_q == wm1) begin
							ox_q       <= '0;
							oy_q       <= oy_q + RW'(1);
							out_slot_q <= (out_slot_q == RSW'(ROW_SLOTS - 1)) ?
								'0 : out_slot_q + RSW'(1);
						end else begin
							ox_q <= ox_q + CW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// A write to any of the three registers restarts the frame; it takes priority over item updates.
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  width_q  <= cfg_data;
					REG_IMAGE_HEIGHT: height_q <= cfg_data;
					REG_KERNEL_SIZE:  ksize_q  <= cfg_data[KSIZE_W-1:0];
					default: ;
				endcase
				if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT ||
					cfg_index == REG_KERNEL_SIZE) begin
					ox_q       <= '0;
					oy_q       <= '0;
					out_slot_q <= '0;
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_slot_q  <= '0;
				end
			end
		end
	end

	a_taps_in_kernel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> (i_q < ks) && (j_q < ks))
		else $error("tap counters beyond kernel size");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(in_col_q < w_eff) && (ox_q < w_eff))
		else $error("column counter beyond image width");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && !(dst_valid_q && dst_stall) |=> dst_valid_q)
		else $error("finished result not presented");

endmodule

@@ verif/imgconv_checker.sv @@
module imgconv_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               src_valid,
	input  logic                               src_stall,
	input  imgconv_pkg::in_item_t              src_data,
	input  logic                               dst_valid,
	input  logic                               dst_stall,
	input  imgconv_pkg::out_item_t             dst_data,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [imgconv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [imgconv_pkg::DIM_W-1:0]      cfg_data,
	output int                                 errors,
	output int                                 pending,
	output bit                                 frame_open,
	output bit                                 frame_full
);
	import imgconv_pkg::*;

	localparam int KMAX  = 19;
	localparam int WMAX  = 2048;
	localparam int HMAX  = 2048;
	localparam int SLOTS = KMAX + 1;

	bit [31:0]       line_mem [SLOTS*WMAX];
	bit [15:0]       coef_mem [KMAX*KMAX];
	int unsigned     width_reg, height_reg, ksize_reg;
	int unsigned     pixels_in, results_out;
	out_item_t       expected_q [$];

	function automatic int unsigned eff_width();
		return (width_reg == 0) ? 1 : (width_reg > WMAX ? WMAX : width_reg);
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg == 0) ? 1 : (height_reg > HMAX ? HMAX : height_reg);
	endfunction

	// Works out the filtered pixel, if any, that one input item releases.
	function automatic void convolve_item(input in_item_t it, output bit emit,
			output out_item_t res);
		int unsigned w, h, ks, half, hp, total, ox, oy, nx, ny;
		int yy, xx;
		longint unsigned acc [4];
		bit [31:0] px;
		emit = 1'b0;
		res = '0;
		w = eff_width();
		h = eff_height();
		ks = (ksize_reg > KMAX) ? KMAX : ksize_reg;
		half = ks / 2;
		hp = (ks == 0) ? 0 : ks - 1 - half;
		total = w * h;
		if (it.op == OP_LOAD) begin
			if (it.coef_row < KMAX && it.coef_col < KMAX)
				coef_mem[it.coef_row*KMAX + it.coef_col] = it.coef_weight;
			return;
		end
		if (it.op != OP_PIXEL && it.op != OP_FLUSH)
			return;
		if (it.op == OP_PIXEL && pixels_in < total) begin
			line_mem[((pixels_in / w) % SLOTS)*WMAX + pixels_in % w] =
				{it.pixel_alpha, it.pixel_blue, it.pixel_green, it.pixel_red};
			pixels_in++;
		end
		if (results_out >= total)
			return;
		oy = results_out / w;
		ox = results_out % w;
		ny = (oy + hp > h - 1) ? h - 1 : oy + hp;
		nx = (ox + hp > w - 1) ? w - 1 : ox + hp;
		if (ny*w + nx >= pixels_in)
			return;
		for (int c = 0; c < 4; c++)
			acc[c] = 0;
		for (int i = 0; i < ks; i++) begin
			yy = int'(oy) + i - int'(half);
			if (yy < 0 || yy >= int'(h))
				continue;
			for (int j = 0; j < ks; j++) begin
				xx = int'(ox) + j - int'(half);
				if (xx < 0 || xx >= int'(w))
					continue;
				px = line_mem[(yy % SLOTS)*WMAX + xx];
				for (int c = 0; c < 4; c++)
					acc[c] += longint'(px[8*c +: 8]) * longint'(coef_mem[i*KMAX + j]);
			end
		end
		for (int c = 0; c < 4; c++) begin
			acc[c] = acc[c] >> WEIGHT_FRAC_BITS;
			if (acc[c] > 255)
				acc[c] = 255;
		end
		res.out_red   = acc[0][7:0];
		res.out_green = acc[1][7:0];
		res.out_blue  = acc[2][7:0];
		res.out_alpha = acc[3][7:0];
		res.out_x     = ox[COORD_W-1:0];
		res.out_y     = oy[COORD_W-1:0];
		results_out++;
		res.last_of_frame = (results_out == total);
		if (res.last_of_frame) begin
			pixels_in = 0;
			results_out = 0;
		end
		emit = 1'b1;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit        emit;
		out_item_t res;
		out_item_t want;
		if (!arst_n) begin
			width_reg = 1920;
			height_reg = 1080;
			ksize_reg = 19;
			pixels_in = 0;
			results_out = 0;
			expected_q.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: width_reg = 32'(cfg_data);
					REG_IMAGE_HEIGHT: height_reg = 32'(cfg_data);
					REG_KERNEL_SIZE: ksize_reg = 32'(cfg_data[KSIZE_W-1:0]);
					default: ;
				endcase
				if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT ||
						cfg_index == REG_KERNEL_SIZE) begin
					pixels_in = 0;
					results_out = 0;
				end
			end
			if (src_valid && !src_stall) begin
				convolve_item(src_data, emit, res);
				if (emit)
					expected_q.push_back(res);
			end
			if (dst_valid && !dst_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected transfer, out_x", dst_data.out_x, -1);
				end else begin
					want = expected_q.pop_front();
					if (dst_data.out_red !== want.out_red)
						report("out_red", dst_data.out_red, want.out_red);
					if (dst_data.out_green !== want.out_green)
						report("out_green", dst_data.out_green, want.out_green);
					if (dst_data.out_blue !== want.out_blue)
						report("out_blue", dst_data.out_blue, want.out_blue);
					if (dst_data.out_alpha !== want.out_alpha)
						report("out_alpha", dst_data.out_alpha, want.out_alpha);
					if (dst_data.out_x !== want.out_x)
						report("out_x", dst_data.out_x, want.out_x);
					if (dst_data.out_y !== want.out_y)
						report("out_y", dst_data.out_y, want.out_y);
					if (dst_data.last_of_frame !== want.last_of_frame)
						report("last_of_frame", dst_data.last_of_frame, want.last_of_frame);
				end
			end
		end
		pending = expected_q.size();
		frame_open = (pixels_in != 0 || results_out != 0);
		frame_full = frame_open && pixels_in >= eff_width() * eff_height();
	end

endmodule

@@ verif/testbench.sv @@
module testbench;
	import imgconv_pkg::*;

	localparam logic [1:0]           OP_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int                   CYCLE_LIMIT = 6_000_000;
	localparam int                   SETTLE = 400;

	logic                 clk;
	logic                 arst_n;
	logic                 src_valid;
	logic                 src_stall;
	in_item_t             src_data;
	logic                 dst_valid;
	logic                 dst_stall;
	out_item_t            dst_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	int  errors, pending;
	bit  frame_open, frame_full;
	int  cycles;
	int  item_count;
	bit  src_no_gaps;

	image_convolution_2d i_dut (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
		.dst_valid(dst_valid), .dst_stall(dst_stall), .dst_data(dst_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	imgconv_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
		.dst_valid(dst_valid), .dst_stall(dst_stall), .dst_data(dst_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending),
		.frame_open(frame_open), .frame_full(frame_full)
	);

	initial clk = 0;
	always #2 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// The receiver stalls for a random number of cycles before each transfer,
	// with occasional stretches where it never stalls.
	initial begin
		int  hold;
		bit  eager;
		dst_stall = 1;
		eager = 0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 40) == 0)
				eager = !eager;
			hold = eager ? 0 : $urandom_range(0, 15);
			@(negedge clk);
			dst_stall = (hold != 0);
			repeat (hold) @(negedge clk);
			dst_stall = 0;
			do @(posedge clk); while (!dst_valid);
		end
	end

	task automatic send(input in_item_t it);
		int gap;
		gap = src_no_gaps ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			src_valid = 0;
			repeat (gap) @(negedge clk);
		end
		src_valid = 1;
		src_data = it;
		do @(posedge clk); while (src_stall);
		@(negedge clk);
		if (it.op != OP_UNUSED)
			item_count++;
	endtask

	task automatic send_op(input logic [1:0] op, input int row, input int col,
			input int weight);
		in_item_t   it;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		it.op = op;
		it.coef_row = COEF_IDX_W'(row);
		it.coef_col = COEF_IDX_W'(col);
		it.coef_weight = WEIGHT_W'(weight);
		send(it);
	endtask

	task automatic send_pixel();
		in_item_t   it;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		it.op = OP_PIXEL;
		case ($urandom_range(0, 15))
			0: {it.pixel_red, it.pixel_green, it.pixel_blue, it.pixel_alpha} = '1;
			1: {it.pixel_red, it.pixel_green, it.pixel_blue, it.pixel_alpha} = '0;
			default: ;
		endcase
		send(it);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = DIM_W'(value);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic wait_idle();
		src_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// One frame: register writes while idle, a few weight reloads, the pixels
	// with noise mixed in, possibly surplus pixels once the frame is full, then flushes until
	// the last row has drained. An abandoned frame stops part way through and is left open.
	task automatic run_frame(input int w, input int h, input int k, input int wmax,
			input bit abandon);
		int ew, eh, total, stop;
		ew = (w == 0) ? 1 : (w > 2048 ? 2048 : w);
		eh = (h == 0) ? 1 : (h > 2048 ? 2048 : h);
		total = ew * eh;
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_KERNEL_SIZE, k);
		src_no_gaps = ($urandom_range(0, 4) == 0);
		repeat ($urandom_range(0, 8))
			send_op(OP_LOAD, $urandom_range(0, 18), $urandom_range(0, 18),
				$urandom_range(0, wmax));
		stop = abandon ? (total > 80 ? 40 : total / 2) : total;
		for (int p = 0; p < stop; p++) begin
			case ($urandom_range(0, 29))
				0: send_op(OP_LOAD, $urandom_range(0, 18), $urandom_range(0, 18),
					$urandom_range(0, wmax));
				1: send_op(OP_LOAD, $urandom_range(19, 31), $urandom_range(0, 31), $urandom);
				2: send_op(OP_UNUSED, 0, 0, 0);
				3: send_op(OP_FLUSH, 0, 0, 0);
				default: ;
			endcase
			send_pixel();
		end
		if (!abandon) begin
			while (frame_full && $urandom_range(0, 2) == 0)
				send_pixel();
			while (frame_open)
				send_op(OP_FLUSH, 0, 0, 0);
		end
	endtask

	initial begin
		int k, w, h, sel;
		arst_n = 0;
		src_valid = 0;
		src_data = '0;
		cfg_valid = 0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		item_count = 0;
		src_no_gaps = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Every weight is loaded before any result can read one.
		for (int r = 0; r < 19; r++)
			for (int c = 0; c < 19; c++)
				send_op(OP_LOAD, r, c, $urandom_range(0, 4095));
		send_op(OP_LOAD, 0, 0, 16'hFFFF);
		send_op(OP_LOAD, 31, 31, 16'hFFFF);
		send_op(OP_LOAD, 19, 0, 0);
		send_op(OP_UNUSED, 0, 0, 0);
		send_op(OP_FLUSH, 0, 0, 0);
		wait_idle();
		write_reg(REG_UNUSED, 12'hFFF);

		run_frame(4095, 1, 1, 4095, 1);
		run_frame(1, 4095, 0, 4095, 1);
		run_frame(0, 0, 19, 4095, 0);
		run_frame(5, 4, 19, 65535, 0);
		run_frame(3, 3, 31, 4095, 0);
		run_frame(4, 3, 2, 65535, 0);
		run_frame(6, 5, 3, 4095, 1);
		run_frame(6, 5, 3, 4095, 0);

		while (item_count < 1200) begin
			w = $urandom_range(0, 9);
			h = $urandom_range(0, 6);
			sel = $urandom_range(0, 15);
			if (sel < 10) k = 2 * $urandom_range(0, 2) + 1;
			else if (sel < 12) k = 2 * $urandom_range(1, 2);
			else if (sel == 12) k = 0;
			else if (sel == 13) k = 2 * $urandom_range(3, 4) + 1;
			else begin
				k = (sel == 14) ? $urandom_range(19, 31) : $urandom_range(11, 17);
				w = $urandom_range(1, 4);
				h = $urandom_range(1, 3);
			end
			case ($urandom_range(0, 2))
				0: run_frame(w, h, k, 65535, $urandom_range(0, 7) == 0);
				1: run_frame(w, h, k, 8191, $urandom_range(0, 7) == 0);
				default: run_frame(w, h, k, 1023, $urandom_range(0, 7) == 0);
			endcase
		end

		wait_idle();
		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ image_convolution_2d.f @@
hdl/imgconv_pkg.sv
hdl/image_convolution_2d.sv
verif/imgconv_checker.sv
verif/testbench.sv
